### src/linear_search_key_table_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the linear search key table
// Short forms for clocked concurrent assertions that are disabled during reset.
// ----------------------------------------------------------------------------
`ifndef LINEAR_SEARCH_KEY_TABLE_MACROS_SVH
`define LINEAR_SEARCH_KEY_TABLE_MACROS_SVH

// Assertion on an explicit clock and reset
`define LSKT_ASSERT_CLK(name, clock, reset, prop, msg) \
  name: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Assertion on the local clk and rst
`define LSKT_ASSERT(name, prop, msg) \
  `LSKT_ASSERT_CLK(name, clk, rst, prop, msg)

`endif

### src/lskt_pkg.sv
// ----------------------------------------------------------------------------
// lskt_pkg
// Sizes, field widths and codes shared by the key table and its checker.
// ----------------------------------------------------------------------------
`default_nettype none

package lskt_pkg;

  localparam int CAPACITY = 16;
  localparam int KEY_BITS = 32;

  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);

  // Stream field widths
  localparam int CMD_W      = 2;
  localparam int KEY_W      = 32;
  localparam int STATUS_W   = 2;
  localparam int POS_W      = 4;
  localparam int ENTRIES_W  = 5;
  localparam int IN_DATA_W  = ((KEY_W + 7) / 8) * 8;
  localparam int OUT_DATA_W = ((POS_W + ENTRIES_W + 7) / 8) * 8;

  // Commands
  localparam logic [CMD_W-1:0] CMD_SEARCH = 2'd0;
  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd1;
  localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd2;

  // Result status
  localparam logic [STATUS_W-1:0] ST_DONE      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_ABSENT    = 2'd1;
  localparam logic [STATUS_W-1:0] ST_DUPLICATE = 2'd2;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd3;

endpackage

`default_nettype wire

### src/linear_search_key_table.sv
// An unordered table of distinct keys held in one synchronous RAM with a
// read port and a write port. Each input word is a search, insert or remove;
// every one returns exactly one result word. One operation is in flight at a
// time. The scan reads one stored key per cycle through the single RAM read
// port. An operation scans the stored keys in order until a hit or the end
// of the table; a remove that hits any entry but the last then moves the
// last entry into the freed slot (one RAM read, one RAM write). An unused
// command code skips the scan and goes straight to the result. The result
// sits in an output register, so the next word is taken while the previous
// result waits; the next result then holds until it drains.
// ----------------------------------------------------------------------------
// linear_search_key_table
// Key table with linear scan, append on insert and swap-with-last on remove.
// ----------------------------------------------------------------------------
`default_nettype none

module linear_search_key_table import lskt_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,   // [31:0] key
  input  wire logic [CMD_W-1:0]      s_axis_tuser,   // [1:0] command
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0]      m_axis_tdata,   // [3:0] position, [8:4] entries_used
  output logic [STATUS_W-1:0]        m_axis_tuser    // [1:0] status
);

  localparam logic [2:0] FSM_IDLE = 3'd0;
  localparam logic [2:0] FSM_SCAN = 3'd1;
  localparam logic [2:0] FSM_MVRD = 3'd2;
  localparam logic [2:0] FSM_MVWR = 3'd3;
  localparam logic [2:0] FSM_RESP = 3'd4;

  logic [KEY_BITS-1:0] key_mem [CAPACITY];

  logic [2:0]          state, state_next;
  logic [CMD_W-1:0]    cmd;
  logic [KEY_BITS-1:0] key;
  logic [CNT_W-1:0]    used, used_next;
  logic [CNT_W-1:0]    issue_idx;
  logic                cmp_valid;
  logic [IDX_W-1:0]    cmp_idx;
  logic [KEY_BITS-1:0] rd_data;
  logic [IDX_W-1:0]    found, found_next;
  logic [STATUS_W-1:0] res_status, res_status_next;
  logic [POS_W-1:0]    res_pos, res_pos_next;
  logic [STATUS_W-1:0] out_status;
  logic [POS_W-1:0]    out_pos;
  logic [ENTRIES_W-1:0] out_used;

  logic                accept;
  logic                hit;
  logic                scan_end;
  logic                load;
  logic                rd_en;
  logic [IDX_W-1:0]    rd_addr;
  logic [IDX_W-1:0]    last_idx;
  logic                wr_en;
  logic [IDX_W-1:0]    wr_addr;
  logic [KEY_BITS-1:0] wr_data;

  assign s_axis_tready = (state == FSM_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign last_idx      = IDX_W'(used - CNT_W'(1));
  assign hit           = (state == FSM_SCAN) && cmp_valid && (rd_data == key);
  assign scan_end      = (state == FSM_SCAN) && !cmp_valid && (issue_idx == used);
  assign load          = (state == FSM_RESP) && (!m_axis_tvalid || m_axis_tready);

  // One RAM read per cycle while scanning; one more to fetch the last entry
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = issue_idx[IDX_W-1:0];
    if (state == FSM_SCAN && !hit && issue_idx < used) begin
      rd_en = 1'b1;
    end
    if (state == FSM_MVRD) begin
      rd_en   = 1'b1;
      rd_addr = last_idx;
    end
  end

  always_comb begin
    state_next      = state;
    used_next       = used;
    found_next      = found;
    res_status_next = res_status;
    res_pos_next    = res_pos;
    wr_en           = 1'b0;
    wr_addr         = used[IDX_W-1:0];
    wr_data         = key;
    unique case (state)
      FSM_IDLE: begin
        if (accept) begin
          case (s_axis_tuser) inside
            CMD_SEARCH, CMD_INSERT, CMD_REMOVE: begin
              state_next = FSM_SCAN;
            end
            default: begin
              res_status_next = ST_DONE;
              res_pos_next    = '0;
              state_next      = FSM_RESP;
            end
          endcase
        end
      end
      FSM_SCAN: begin
        if (hit) begin
          found_next   = cmp_idx;
          res_pos_next = POS_W'(cmp_idx);
          state_next   = FSM_RESP;
          case (cmd)
            CMD_INSERT: res_status_next = ST_DUPLICATE;
            CMD_REMOVE: begin
              res_status_next = ST_DONE;
              // Last entry: just release it; otherwise move the last one down
              if (cmp_idx == last_idx) begin
                used_next = used - CNT_W'(1);
              end else begin
                state_next = FSM_MVRD;
              end
            end
            default: res_status_next = ST_DONE;
          endcase
        end else if (scan_end) begin
          state_next      = FSM_RESP;
          res_status_next = ST_ABSENT;
          res_pos_next    = '0;
          if (cmd == CMD_INSERT) begin
            if (used >= CNT_W'(CAPACITY)) begin
              res_status_next = ST_FULL;
            end else begin
              wr_en           = 1'b1;
              res_status_next = ST_DONE;
              res_pos_next    = POS_W'(used);
              used_next       = used + CNT_W'(1);
            end
          end
        end
      end
      FSM_MVRD: begin
        state_next = FSM_MVWR;
      end
      FSM_MVWR: begin
        wr_en      = 1'b1;
        wr_addr    = found;
        wr_data    = rd_data;
        used_next  = used - CNT_W'(1);
        state_next = FSM_RESP;
      end
      FSM_RESP: begin
        if (load) begin
          state_next = FSM_IDLE;
        end
      end
      default: begin
        state_next = FSM_IDLE;
      end
    endcase
  end

  // Key RAM: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      key_mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= key_mem[rd_addr];
      cmp_idx <= rd_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= FSM_IDLE;
      used          <= '0;
      issue_idx     <= '0;
      cmp_valid     <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      state     <= state_next;
      used      <= used_next;
      cmp_valid <= rd_en && (state == FSM_SCAN);
      if (state == FSM_IDLE) begin
        issue_idx <= '0;
      end else if (rd_en && state == FSM_SCAN) begin
        issue_idx <= issue_idx + CNT_W'(1);
      end
      if (load) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd <= s_axis_tuser;
      key <= KEY_BITS'(s_axis_tdata[KEY_W-1:0]);
    end
    found      <= found_next;
    res_status <= res_status_next;
    res_pos    <= res_pos_next;
    if (load) begin
      out_status <= res_status;
      out_pos    <= res_pos;
      out_used   <= ENTRIES_W'(used);
    end
  end

  assign m_axis_tuser = out_status;
  assign m_axis_tdata = OUT_DATA_W'({out_used, out_pos});

endmodule

`default_nettype wire

### src/lskt_checker.sv
// ----------------------------------------------------------------------------
// lskt_checker
// Port-level checks on the key table result stream.
// ----------------------------------------------------------------------------
`default_nettype none

`include "linear_search_key_table_macros.svh"

module lskt_checker import lskt_pkg::*; (
  input wire logic                  clk,
  input wire logic                  rst,
  input wire logic                  m_axis_tvalid,
  input wire logic                  m_axis_tready,
  input wire logic [OUT_DATA_W-1:0] m_axis_tdata,   // [3:0] position, [8:4] entries_used
  input wire logic [STATUS_W-1:0]   m_axis_tuser    // [1:0] status
);

  logic [POS_W-1:0]     pos;
  logic [ENTRIES_W-1:0] entries;

  assign pos     = m_axis_tdata[POS_W-1:0];
  assign entries = m_axis_tdata[POS_W +: ENTRIES_W];

  // A stalled result word holds
  `LSKT_ASSERT(a_out_hold, (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)), "result word changed while stalled")

  `LSKT_ASSERT(a_count_range, m_axis_tvalid |-> (entries <= ENTRIES_W'(CAPACITY)), "entry count above capacity")

  // Full is reported only when every entry is in use
  `LSKT_ASSERT(a_full_count, (m_axis_tvalid && m_axis_tuser == ST_FULL) |-> (entries == ENTRIES_W'(CAPACITY)), "full reported below capacity")

  // Misses and full rejections carry no position
  `LSKT_ASSERT(a_miss_pos, (m_axis_tvalid && (m_axis_tuser == ST_ABSENT || m_axis_tuser == ST_FULL)) |-> (pos == '0), "nonzero position on miss")

  // A position reported with a duplicate lies below the entry count
  `LSKT_ASSERT(a_pos_range, (m_axis_tvalid && m_axis_tuser == ST_DUPLICATE) |-> (ENTRIES_W'(pos) < entries), "duplicate position beyond count")

endmodule

bind linear_search_key_table lskt_checker u_lskt_checker (.*);

`default_nettype wire
